// ===== src/cdsch_pkg.sv =====
// ============================================================================
// cdsch_pkg
// Shared constants and types for the C-LOOK disk scheduling core.
// ============================================================================
package cdsch_pkg;

    localparam int MAX_REQUESTS = 63;
    localparam int CYL_BITS     = 16;
    localparam int COUNT_BITS   = $clog2(MAX_REQUESTS + 1);
    localparam int TRAVEL_BITS  = CYL_BITS + 2;
    localparam int IN_TDATA_W   = ((CYL_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_W  = ((CYL_BITS + TRAVEL_BITS + 7) / 8) * 8;

    typedef logic [CYL_BITS-1:0]    t_cyl;
    typedef logic [COUNT_BITS-1:0]  t_count;
    typedef logic [TRAVEL_BITS-1:0] t_travel;

    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_INSERT = 2'd1,
        OP_SHIFT  = 2'd2
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        t_cyl     value;
        t_count   count;
    } t_cell_cmd;

endpackage

// ===== src/cdsch_cell.sv =====
// ============================================================================
// cdsch_cell
// One slot of the descending request chain: sorted insert from the left
// neighbor, shift toward the head from the right neighbor.
// ============================================================================
module cdsch_cell (
    input  logic                 i_clk,
    input  cdsch_pkg::t_count    i_index,
    input  cdsch_pkg::t_cell_cmd i_cmd,
    input  cdsch_pkg::t_cyl      i_left_val,
    input  logic                 i_left_keep,
    input  cdsch_pkg::t_cyl      i_right_val,
    output cdsch_pkg::t_cyl      o_val,
    output logic                 o_keep
);

    cdsch_pkg::t_cyl r_val;
    cdsch_pkg::t_cyl n_val;
    cdsch_pkg::t_count w_tail;

    assign w_tail = i_cmd.count - cdsch_pkg::t_count'(1);
    assign o_keep = (i_index < i_cmd.count) && (r_val >= i_cmd.value);
    assign o_val  = r_val;

    always_comb begin
        n_val = r_val;
        case (i_cmd.op)
            cdsch_pkg::OP_INSERT: begin
                if (o_keep) begin
                    n_val = r_val;
                end else if (i_left_keep) begin
                    n_val = i_cmd.value;
                end else begin
                    n_val = i_left_val;
                end
            end
            cdsch_pkg::OP_SHIFT: begin
                n_val = (i_index == w_tail) ? i_cmd.value : i_right_val;
            end
            default: n_val = r_val;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule

// ===== src/clook_disk_schedule_core.sv =====
// ============================================================================
// clook_disk_schedule_core
// C-LOOK scheduler: sorts a batch of cylinder requests and emits the
// visiting order with the total head travel.
// ============================================================================
// Requests enter one word per cycle into a chain of 63 cells kept in
// descending order; a request that arrives with the chain full is dropped.
// The word with tlast set also samples the start cylinder register and
// closes the batch. The chain then rotates requests at or above the start
// to its tail, one cell shift per cycle (up to the number of such
// requests), after which one word per cycle leaves while the output is
// not stalled: the start cylinder, then the requests below it descending,
// then the requests above it descending. Requests equal to the start are
// dropped. The last word has tlast set and carries the total travel in the
// upper field. No request is taken while a batch is being rotated or
// emitted: the input stays closed from the tlast word until the last word
// of the batch is loaded into the output register.
module clook_disk_schedule_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [cdsch_pkg::CYL_BITS-1:0]      i_cfg_wdata,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  logic [cdsch_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,  // request_cylinder
    input  logic                                i_s_axis_tlast,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    output logic [cdsch_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata,  // served_cylinder, total_travel
    output logic                                o_m_axis_tlast
);

    localparam int NCELL = cdsch_pkg::MAX_REQUESTS;

    typedef enum logic [3:0] {
        ST_LOAD  = 4'b0001,
        ST_ROT   = 4'b0010,
        ST_START = 4'b0100,
        ST_EMIT  = 4'b1000
    } t_state;

    t_state                r_state, n_state;
    cdsch_pkg::t_count     r_count, n_count;
    cdsch_pkg::t_count     r_rot_left, n_rot_left;
    cdsch_pkg::t_cyl       r_cfg_start;
    cdsch_pkg::t_cyl       r_start, n_start;
    cdsch_pkg::t_cyl       r_prev, n_prev;
    cdsch_pkg::t_travel    r_travel, n_travel;
    logic                  r_out_valid, n_out_valid;
    cdsch_pkg::t_cyl       r_out_cyl, n_out_cyl;
    logic                  r_out_last, n_out_last;
    cdsch_pkg::t_travel    r_out_travel, n_out_travel;

    cdsch_pkg::t_cell_cmd  w_cmd;
    cdsch_pkg::t_cyl       w_val  [NCELL];
    logic                  w_keep [NCELL];
    cdsch_pkg::t_cyl       w_head;
    cdsch_pkg::t_cyl       w_diff;
    cdsch_pkg::t_travel    w_sum;
    logic                  w_in_acc;
    logic                  w_out_free;

    assign w_head     = w_val[0];
    assign w_in_acc   = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free = !r_out_valid || i_m_axis_tready;
    assign w_diff     = (w_head > r_prev) ? (w_head - r_prev) : (r_prev - w_head);
    assign w_sum      = r_travel + cdsch_pkg::t_travel'(w_diff);

    assign o_s_axis_tready = (r_state == ST_LOAD);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tlast  = r_out_last;
    assign o_m_axis_tdata  = cdsch_pkg::OUT_TDATA_W'({r_out_travel, r_out_cyl});

    for (genvar g = 0; g < NCELL; g++) begin : g_cell
        cdsch_pkg::t_cyl w_left_val;
        cdsch_pkg::t_cyl w_right_val;
        logic            w_left_keep;

        if (g == 0) begin : g_first
            assign w_left_val  = w_cmd.value;
            assign w_left_keep = 1'b1;
        end else begin : g_mid
            assign w_left_val  = w_val[g-1];
            assign w_left_keep = w_keep[g-1];
        end

        if (g == NCELL - 1) begin : g_last
            assign w_right_val = w_cmd.value;
        end else begin : g_inner
            assign w_right_val = w_val[g+1];
        end

        cdsch_cell u_cell (
            .i_clk       (i_clk),
            .i_index     (cdsch_pkg::t_count'(g)),
            .i_cmd       (w_cmd),
            .i_left_val  (w_left_val),
            .i_left_keep (w_left_keep),
            .i_right_val (w_right_val),
            .o_val       (w_val[g]),
            .o_keep      (w_keep[g])
        );
    end

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_rot_left   = r_rot_left;
        n_start      = r_start;
        n_prev       = r_prev;
        n_travel     = r_travel;
        n_out_valid  = r_out_valid && !i_m_axis_tready;
        n_out_cyl    = r_out_cyl;
        n_out_last   = r_out_last;
        n_out_travel = r_out_travel;
        w_cmd.op     = cdsch_pkg::OP_HOLD;
        w_cmd.value  = w_head;
        w_cmd.count  = r_count;

        unique case (r_state)
            ST_LOAD: begin
                if (w_in_acc) begin
                    if (r_count != cdsch_pkg::t_count'(NCELL)) begin
                        w_cmd.op    = cdsch_pkg::OP_INSERT;
                        w_cmd.value = i_s_axis_tdata[cdsch_pkg::CYL_BITS-1:0];
                        n_count     = r_count + cdsch_pkg::t_count'(1);
                    end
                    if (i_s_axis_tlast) begin
                        n_start    = r_cfg_start;
                        n_rot_left = n_count;
                        n_state    = ST_ROT;
                    end
                end
            end
            ST_ROT: begin
                if (r_rot_left == '0 || w_head < r_start) begin
                    n_state = ST_START;
                end else begin
                    w_cmd.op   = cdsch_pkg::OP_SHIFT;
                    n_rot_left = r_rot_left - cdsch_pkg::t_count'(1);
                    if (w_head == r_start) begin
                        n_count = r_count - cdsch_pkg::t_count'(1);
                    end
                end
            end
            ST_START: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_cyl    = r_start;
                    n_out_last   = (r_count == '0);
                    n_out_travel = '0;
                    n_prev       = r_start;
                    n_travel     = '0;
                    n_state      = (r_count == '0) ? ST_LOAD : ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (w_out_free) begin
                    w_cmd.op     = cdsch_pkg::OP_SHIFT;
                    n_count      = r_count - cdsch_pkg::t_count'(1);
                    n_out_valid  = 1'b1;
                    n_out_cyl    = w_head;
                    n_out_last   = (r_count == cdsch_pkg::t_count'(1));
                    n_out_travel = n_out_last ? w_sum : '0;
                    n_prev       = w_head;
                    n_travel     = w_sum;
                    if (r_count == cdsch_pkg::t_count'(1)) begin
                        n_state = ST_LOAD;
                    end
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_count     <= '0;
            r_rot_left  <= '0;
            r_cfg_start <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_rot_left  <= n_rot_left;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_cfg_start <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_start      <= n_start;
        r_prev       <= n_prev;
        r_travel     <= n_travel;
        r_out_cyl    <= n_out_cyl;
        r_out_last   <= n_out_last;
        r_out_travel <= n_out_travel;
    end

endmodule
